/* rtl/core/swma_pkg.sv */
// shared constants and types for the ssim window moment accumulator
package swma_pkg;

   localparam int MAX_TAPS = 14;
   localparam int PIX_W    = 16;
   localparam int WGT_W    = 9;
   localparam int CNT_W    = 4;
   localparam int KWORD_W  = 63;
   localparam int KERN_W   = 2 * KWORD_W;
   localparam int SUM_W    = 28;
   localparam int SQ_W     = 44;
   localparam int WTOT_W   = 12;

   localparam logic [1:0] CSR_TAP_COUNT  = 2'd0;
   localparam logic [1:0] CSR_TAP_CENTER = 2'd1;
   localparam logic [1:0] CSR_KERNEL_0   = 2'd2;
   localparam logic [1:0] CSR_KERNEL_1   = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0]  taps;
      logic [CNT_W-1:0]  centre;
      logic [KERN_W-1:0] kernel;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] ref_pixel;
      logic [PIX_W-1:0] test_pixel;
      logic             row_end;
      logic [CNT_W-1:0] seen;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] first_d;
   } cmd_type;

   typedef struct packed {
      logic [SUM_W-1:0]  ref_sum;
      logic [SUM_W-1:0]  test_sum;
      logic [SQ_W-1:0]   ref_square_sum;
      logic [SQ_W-1:0]   cross_sum;
      logic [SQ_W-1:0]   test_square_sum;
      logic [WTOT_W-1:0] weight_total;
      logic              row_last;
   } rsp_type;

endpackage

/* rtl/core/swma_front.sv */
// front end: row position tracking, result count per item and command queue
module swma_front (
   input  logic                  clock,
   input  logic                  reset,
   input  swma_pkg::cfg_type     cfg,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [15:0]           req_ref_pixel,
   input  logic [15:0]           req_test_pixel,
   input  logic                  req_row_end,
   output logic                  cmd_valid,
   output swma_pkg::cmd_type     cmd,
   input  logic                  cmd_pop
);
   import swma_pkg::*;

   logic [CNT_W-1:0] seen_ff, seen_in;
   cmd_type          q_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [CNT_W:0]   lag;
   logic [CNT_W-1:0] lag_n;
   cmd_type          new_cmd;
   logic             push, pop;

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      if ({1'b0, cfg.taps} > {1'b0, cfg.centre} + 5'd1) begin
         lag = {1'b0, cfg.taps} - {1'b0, cfg.centre} - 5'd1;
      end else begin
         lag = '0;
      end
      lag_n = lag[CNT_W-1:0];
      new_cmd.ref_pixel  = req_ref_pixel;
      new_cmd.test_pixel = req_test_pixel;
      new_cmd.row_end    = req_row_end;
      new_cmd.seen       = seen_ff;
      if (req_row_end) begin
         new_cmd.first_d = (seen_ff < lag_n) ? seen_ff : lag_n;
         new_cmd.count   = new_cmd.first_d + 4'd1;
      end else begin
         new_cmd.first_d = lag_n;
         new_cmd.count   = (seen_ff >= lag_n) ? 4'd1 : 4'd0;
      end
      if (req_row_end) begin
         seen_in = '0;
      end else if (seen_ff == 4'd15) begin
         seen_in = seen_ff;
      end else begin
         seen_in = seen_ff + 4'd1;
      end
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (push) begin
            seen_ff <= seen_in;
         end
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

/* rtl/core/swma_back.sv */
// back end: pixel window, tap-serial moment accumulation and result queue
module swma_back (
   input  logic                  clock,
   input  logic                  reset,
   input  swma_pkg::cfg_type     cfg,
   input  logic                  cmd_valid,
   input  swma_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output swma_pkg::rsp_type     rsp
);
   import swma_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [2*PIX_W-1:0] win_ff [MAX_TAPS];
   logic [CNT_W-1:0]   k_ff, k_in, d_ff, d_in, rem_ff, rem_in, seen_ff;
   logic               end_ff;
   // tap pipeline
   logic               a_v_ff, b_v_ff;
   logic [WGT_W-1:0]   a_w_ff, b_w_ff;
   logic [PIX_W-1:0]   a_r_ff, a_t_ff, b_r_ff, b_t_ff;
   logic [WGT_W+PIX_W-1:0] b_wr_ff, b_wt_ff;
   logic [29:0]        acc_r_ff, acc_t_ff;
   logic [45:0]        acc_rr_ff, acc_rt_ff, acc_tt_ff;
   logic [12:0]        acc_w_ff;
   // result queue
   rsp_type            rq_ff [2];
   logic               rq_wr_ff, rq_rd_ff;
   logic [1:0]         rq_cnt_ff;

   logic               issue, acc_clr, rq_push, rq_pop;
   logic [CNT_W:0]     pos_sum, idx;
   logic               in_row;
   logic [WGT_W-1:0]   tap_w;
   rsp_type            res;

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign issue     = (state_ff == ST_RUN) && (k_ff != cfg.taps);
   assign rq_push   = (state_ff == ST_OUT) && (rq_cnt_ff != 2'd2);
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_empty = (rq_cnt_ff == 2'd0);
   assign rsp       = rq_ff[rq_rd_ff];

   always_comb begin
      pos_sum = {1'b0, d_ff} + {1'b0, cfg.centre};
      idx     = pos_sum - {1'b0, k_ff};
      in_row  = (pos_sum >= {1'b0, k_ff}) && (idx <= {1'b0, seen_ff})
                && (idx < 5'(MAX_TAPS));
      tap_w   = cfg.kernel[k_ff*WGT_W +: WGT_W];
   end

   always_comb begin
      res.ref_sum         = (|acc_r_ff[29:28]) ? '1 : acc_r_ff[27:0];
      res.test_sum        = (|acc_t_ff[29:28]) ? '1 : acc_t_ff[27:0];
      res.ref_square_sum  = (|acc_rr_ff[45:44]) ? '1 : acc_rr_ff[43:0];
      res.cross_sum       = (|acc_rt_ff[45:44]) ? '1 : acc_rt_ff[43:0];
      res.test_square_sum = (|acc_tt_ff[45:44]) ? '1 : acc_tt_ff[43:0];
      res.weight_total    = acc_w_ff[12] ? '1 : acc_w_ff[11:0];
      res.row_last        = end_ff && (d_ff == '0);
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      rem_in   = rem_ff;
      acc_clr  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               d_in   = cmd.first_d;
               rem_in = cmd.count;
               k_in   = '0;
               if (cmd.count != '0) begin
                  acc_clr  = 1'b1;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               k_in = k_ff + 4'd1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!a_v_ff && !b_v_ff) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rq_push) begin
               if (rem_ff > 4'd1) begin
                  rem_in   = rem_ff - 4'd1;
                  d_in     = d_ff - 4'd1;
                  k_in     = '0;
                  acc_clr  = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         rq_wr_ff  <= 1'b0;
         rq_rd_ff  <= 1'b0;
         rq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         a_v_ff    <= issue;
         b_v_ff    <= a_v_ff;
         if (rq_push) begin
            rq_wr_ff <= !rq_wr_ff;
         end
         if (rq_pop) begin
            rq_rd_ff <= !rq_rd_ff;
         end
         rq_cnt_ff <= rq_cnt_ff + {1'b0, rq_push} - {1'b0, rq_pop};
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      if (cmd_pop) begin
         seen_ff <= cmd.seen;
         end_ff  <= cmd.row_end;
         for (int i = MAX_TAPS - 1; i > 0; i--) begin
            win_ff[i] <= win_ff[i-1];
         end
         win_ff[0] <= {cmd.ref_pixel, cmd.test_pixel};
      end
      // out-of-row taps carry zero weight and zero pixels
      a_w_ff  <= in_row ? tap_w : '0;
      a_r_ff  <= in_row ? win_ff[idx[CNT_W-1:0]][2*PIX_W-1:PIX_W] : '0;
      a_t_ff  <= in_row ? win_ff[idx[CNT_W-1:0]][PIX_W-1:0] : '0;
      b_w_ff  <= a_w_ff;
      b_r_ff  <= a_r_ff;
      b_t_ff  <= a_t_ff;
      b_wr_ff <= (WGT_W+PIX_W)'(a_w_ff) * (WGT_W+PIX_W)'(a_r_ff);
      b_wt_ff <= (WGT_W+PIX_W)'(a_w_ff) * (WGT_W+PIX_W)'(a_t_ff);
      if (acc_clr) begin
         acc_r_ff  <= '0;
         acc_t_ff  <= '0;
         acc_rr_ff <= '0;
         acc_rt_ff <= '0;
         acc_tt_ff <= '0;
         acc_w_ff  <= '0;
      end else if (b_v_ff) begin
         acc_r_ff  <= acc_r_ff + 30'(b_wr_ff);
         acc_t_ff  <= acc_t_ff + 30'(b_wt_ff);
         acc_rr_ff <= acc_rr_ff + 46'(41'(b_wr_ff) * 41'(b_r_ff));
         acc_rt_ff <= acc_rt_ff + 46'(41'(b_wr_ff) * 41'(b_t_ff));
         acc_tt_ff <= acc_tt_ff + 46'(41'(b_wt_ff) * 41'(b_t_ff));
         acc_w_ff  <= acc_w_ff + 13'(b_w_ff);
      end
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

endmodule

/* rtl/core/ssim_window_moment_accumulator.sv */
// top level: weighted window moments over a row of pixel pairs for ssim
//
// input queue: req_push / req_full carry one reference and one distorted
// pixel per item, req_row_end on the row's last pixel.
// result queue: rsp_empty / rsp_pop; the oldest result sits on rsp_* while
// rsp_empty is low. each result holds six weighted window sums and row_last.
// config: csr_wr_en, csr_index, csr_data; write only while the block is idle.
// a pixel gives one result once the window past the kernel centre is filled,
// none before that, and the last pixel of a row flushes all pending ones.
// the front takes each item into a two-entry command queue.
// the back evaluates taps one per cycle through a two-stage multiplier
// pipeline and pops the next command only once all results of the last
// one are queued; a row end can give up to 14 results.
// reset empties both queues and restarts the row; the pixel window itself
// is not cleared. while rsp_pop stays low, two results wait in the output
// queue, then the back stalls and req_full rises once commands pile up.
module ssim_window_moment_accumulator (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [62:0] csr_data,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_ref_pixel,
   input  logic [15:0] req_test_pixel,
   input  logic        req_row_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [27:0] rsp_ref_sum,
   output logic [27:0] rsp_test_sum,
   output logic [43:0] rsp_ref_square_sum,
   output logic [43:0] rsp_cross_sum,
   output logic [43:0] rsp_test_square_sum,
   output logic [11:0] rsp_weight_total,
   output logic        rsp_row_last
);
   import swma_pkg::*;

   logic [CNT_W-1:0]   tap_count_ff, tap_center_ff;
   logic [KWORD_W-1:0] kernel0_ff, kernel1_ff;
   cfg_type            cfg;
   logic               cmd_valid, cmd_pop;
   cmd_type            cmd;
   rsp_type            rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff  <= 4'd9;
         tap_center_ff <= 4'd4;
         kernel0_ff    <= '0;
         kernel1_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TAP_COUNT:  tap_count_ff  <= csr_data[CNT_W-1:0];
            CSR_TAP_CENTER: tap_center_ff <= csr_data[CNT_W-1:0];
            CSR_KERNEL_0:   kernel0_ff    <= csr_data;
            CSR_KERNEL_1:   kernel1_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.taps   = (tap_count_ff > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : tap_count_ff;
      cfg.centre = (tap_center_ff > 4'(MAX_TAPS - 1)) ? 4'(MAX_TAPS - 1) : tap_center_ff;
      cfg.kernel = {kernel1_ff, kernel0_ff};
   end

   swma_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_ref_pixel  (req_ref_pixel),
      .req_test_pixel (req_test_pixel),
      .req_row_end    (req_row_end),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   swma_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_ref_sum         = rsp.ref_sum;
   assign rsp_test_sum        = rsp.test_sum;
   assign rsp_ref_square_sum  = rsp.ref_square_sum;
   assign rsp_cross_sum       = rsp.cross_sum;
   assign rsp_test_square_sum = rsp.test_square_sum;
   assign rsp_weight_total    = rsp.weight_total;
   assign rsp_row_last        = rsp.row_last;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_cross_sum)
         && $stable(rsp_row_last))
      else $error("waiting result changed");

   a_no_taps_no_weight: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_weight_total == '0 |-> rsp_ref_sum == '0 && rsp_test_sum == '0)
      else $error("sums without weight");

endmodule

/* tb/sv/ssim_window_moment_accumulator_test.sv */
// testbench for the ssim window moment accumulator: directed table, random rows, predictor
`timescale 1ns / 1ps

module ssim_window_moment_accumulator_test;
   import swma_pkg::*;

   typedef struct {
      logic [15:0] ref_pixel;
      logic [15:0] test_pixel;
      logic        row_end;
      bit          has_check;
      rsp_type     check;
   } pixel_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [62:0] csr_data;
   logic        req_push;
   logic        req_full;
   logic [15:0] req_ref_pixel;
   logic [15:0] req_test_pixel;
   logic        req_row_end;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [27:0] rsp_ref_sum;
   logic [27:0] rsp_test_sum;
   logic [43:0] rsp_ref_square_sum;
   logic [43:0] rsp_cross_sum;
   logic [43:0] rsp_test_square_sum;
   logic [11:0] rsp_weight_total;
   logic        rsp_row_last;

   ssim_window_moment_accumulator DUT (.*);

   logic [3:0]  model_taps;
   logic [3:0]  model_centre;
   logic [62:0] model_kword [2];
   logic [31:0] model_window [MAX_TAPS];
   int          model_seen;

   rsp_type     moments_due [$];
   int          errors;
   int          send_idle;
   int          take_idle;
   int          directed_count;
   pixel_row_type stim_table [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("*** FAILED ***");
      $finish;
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic logic [8:0] tap_weight(input int k);
      logic [62:0] word;
      word = model_kword[k / 7];
      return word[9 * (k % 7) +: 9];
   endfunction

   function automatic rsp_type window_moments(input int d, input int taps, input int centre,
                                              input bit last);
      logic [63:0] s1, s2, q1, qx, q2, wt, w, r, t;
      int idx;
      rsp_type o;
      s1 = 0; s2 = 0; q1 = 0; qx = 0; q2 = 0; wt = 0;
      for (int k = 0; k < taps; k++) begin
         idx = d + centre - k;
         if (idx < 0 || idx > model_seen || idx >= MAX_TAPS) continue;
         w = 64'(tap_weight(k));
         r = 64'(model_window[idx][31:16]);
         t = 64'(model_window[idx][15:0]);
         s1 += w * r; s2 += w * t;
         q1 += w * r * r; qx += w * r * t; q2 += w * t * t;
         wt += w;
      end
      o.ref_sum         = (s1 > 64'hFFFFFFF) ? '1 : s1[27:0];
      o.test_sum        = (s2 > 64'hFFFFFFF) ? '1 : s2[27:0];
      o.ref_square_sum  = (q1 > 64'hFFFFFFFFFFF) ? '1 : q1[43:0];
      o.cross_sum       = (qx > 64'hFFFFFFFFFFF) ? '1 : qx[43:0];
      o.test_square_sum = (q2 > 64'hFFFFFFFFFFF) ? '1 : q2[43:0];
      o.weight_total    = (wt > 64'hFFF) ? '1 : wt[11:0];
      o.row_last        = last;
      return o;
   endfunction

   // returns the number of results caused by this pixel
   function automatic int predict_pixel(input logic [15:0] rp, input logic [15:0] tp,
                                        input logic row_end);
      int taps, centre, lag, d, n;
      taps   = (model_taps > MAX_TAPS) ? MAX_TAPS : model_taps;
      centre = (model_centre > MAX_TAPS - 1) ? MAX_TAPS - 1 : model_centre;
      lag    = taps - 1 - centre;
      if (lag < 0) lag = 0;
      n = 0;
      for (int i = MAX_TAPS - 1; i > 0; i--) model_window[i] = model_window[i - 1];
      model_window[0] = {rp, tp};
      if (row_end) begin
         d = (model_seen < lag) ? model_seen : lag;
         for (; d >= 0; d--) begin
            moments_due.push_back(window_moments(d, taps, centre, d == 0));
            n++;
         end
         model_seen = 0;
      end else begin
         if (model_seen >= lag) begin
            moments_due.push_back(window_moments(lag, taps, centre, 1'b0));
            n = 1;
         end
         if (model_seen < 15) model_seen++;
      end
      return n;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [62:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TAP_COUNT:  model_taps     = value[3:0];
         CSR_TAP_CENTER: model_centre   = value[3:0];
         CSR_KERNEL_0:   model_kword[0] = value;
         default:        model_kword[1] = value;
      endcase
   endtask

   task automatic drain();
      while (moments_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [15:0] rp, input logic [15:0] tp, input logic row_end);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_ref_pixel  <= rp;
      req_test_pixel <= tp;
      req_row_end    <= row_end;
      @(posedge clock);
      while (req_full) @(posedge clock);
      void'(predict_pixel(rp, tp, row_end));
   endtask

   task automatic stop_sending();
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [62:0] random_kernel(input int mode);
      logic [62:0] v;
      for (int i = 0; i < 7; i++)
         v[9 * i +: 9] = (mode == 0) ? 9'h1FF :
                         (mode == 1) ? 9'($urandom_range(3)) : 9'($urandom);
      return v;
   endfunction

   task automatic random_row();
      int len;
      logic [15:0] rp, tp;
      len = ($urandom_range(9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         rp = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
         tp = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
         send_pixel(rp, tp, i == len - 1);
      end
      stop_sending();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (moments_due.size() == 0) begin
            report("unexpected item", 0, 0);
         end else begin
            rsp_type e;
            e = moments_due.pop_front();
            if (rsp_ref_sum !== e.ref_sum)
               report("ref_sum", 64'(rsp_ref_sum), 64'(e.ref_sum));
            if (rsp_test_sum !== e.test_sum)
               report("test_sum", 64'(rsp_test_sum), 64'(e.test_sum));
            if (rsp_ref_square_sum !== e.ref_square_sum)
               report("ref_square_sum", 64'(rsp_ref_square_sum), 64'(e.ref_square_sum));
            if (rsp_cross_sum !== e.cross_sum)
               report("cross_sum", 64'(rsp_cross_sum), 64'(e.cross_sum));
            if (rsp_test_square_sum !== e.test_square_sum)
               report("test_square_sum", 64'(rsp_test_square_sum), 64'(e.test_square_sum));
            if (rsp_weight_total !== e.weight_total)
               report("weight_total", 64'(rsp_weight_total), 64'(e.weight_total));
            if (rsp_row_last !== e.row_last)
               report("row_last", 64'(rsp_row_last), 64'(e.row_last));
         end
      end
      rsp_pop <= ($urandom_range(99) >= take_idle);
   end

   task automatic add_row(input logic [15:0] rp, input logic [15:0] tp, input logic row_end);
      pixel_row_type r;
      r.ref_pixel = rp; r.test_pixel = tp; r.row_end = row_end;
      r.has_check = 1'b0; r.check = '0;
      stim_table.push_back(r);
   endtask

   task automatic add_checked_row(input logic [15:0] rp, input logic [15:0] tp,
                                  input rsp_type chk);
      pixel_row_type r;
      r.ref_pixel = rp; r.test_pixel = tp; r.row_end = 1'b1;
      r.has_check = 1'b1; r.check = chk;
      stim_table.push_back(r);
   endtask

   task automatic run_table();
      foreach (stim_table[i]) begin
         if (stim_table[i].has_check && moments_due.size() == 0) begin
            send_pixel(stim_table[i].ref_pixel, stim_table[i].test_pixel,
                       stim_table[i].row_end);
            if (moments_due.size() != 0 && moments_due[$] != stim_table[i].check)
               report("table item", 64'(moments_due[$].ref_sum),
                      64'(stim_table[i].check.ref_sum));
         end else begin
            send_pixel(stim_table[i].ref_pixel, stim_table[i].test_pixel,
                       stim_table[i].row_end);
         end
         directed_count++;
      end
      stop_sending();
      stim_table.delete();
   endtask

   initial begin
      rsp_type full_one;
      clock = 1'b0;
      errors = 0;
      directed_count = 0;
      send_idle = 0;
      take_idle = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0; csr_index = CSR_TAP_COUNT; csr_data = '0;
      req_push = 1'b0; req_ref_pixel = '0; req_test_pixel = '0; req_row_end = 1'b0;
      rsp_pop = 1'b0;
      model_taps = 4'd9; model_centre = 4'd4;
      model_kword[0] = '0; model_kword[1] = '0;
      model_seen = 0;
      for (int i = 0; i < MAX_TAPS; i++) model_window[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset the kernel is all zero
      for (int i = 0; i < 6; i++) add_row(16'h1234, 16'h5678, 1'b0);
      add_row(16'hFFFF, 16'h0000, 1'b1);
      // single-tap kernel, lone pixel: result reads straight off the pixel
      full_one = '{ref_sum: 28'd511 * 28'd65535, test_sum: 28'd511 * 28'd65535,
                   ref_square_sum: 44'd511 * 44'd65535 * 44'd65535,
                   cross_sum: 44'd511 * 44'd65535 * 44'd65535,
                   test_square_sum: 44'd511 * 44'd65535 * 44'd65535,
                   weight_total: 12'd511, row_last: 1'b1};
      run_table();
      drain();
      write_reg(CSR_TAP_COUNT, 63'd1);
      write_reg(CSR_TAP_CENTER, 63'd0);
      write_reg(CSR_KERNEL_0, random_kernel(0));
      write_reg(CSR_KERNEL_1, random_kernel(0));
      add_checked_row(16'hFFFF, 16'hFFFF, full_one);
      add_row(16'h0000, 16'h0000, 1'b1);
      run_table();
      drain();
      // fourteen full weights of max pixels saturate
      write_reg(CSR_TAP_COUNT, 63'd15);
      write_reg(CSR_TAP_CENTER, 63'd15);
      for (int i = 0; i < 16; i++) add_row(16'hFFFF, 16'hFFFF, i == 15);
      run_table();
      drain();
      write_reg(CSR_TAP_CENTER, 63'd0);
      for (int i = 0; i < 3; i++) add_row(16'h00FF, 16'h8001, i == 2);
      run_table();
      drain();
      write_reg(CSR_TAP_COUNT, 63'd0);
      add_row(16'h0001, 16'h0002, 1'b0);
      add_row(16'h0003, 16'h0004, 1'b1);
      run_table();
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 37 : (phase == 1) ? 66 : 0;
         take_idle = (phase == 0) ? 66 : (phase == 1) ? 37 : 0;
         for (int set = 0; set < 3; set++) begin
            drain();
            write_reg(CSR_TAP_COUNT, 63'($urandom_range(15)));
            write_reg(CSR_TAP_CENTER, 63'($urandom_range(15)));
            write_reg(CSR_KERNEL_0, random_kernel(int'($urandom_range(2))));
            write_reg(CSR_KERNEL_1, random_kernel(int'($urandom_range(2))));
            for (int r = 0; r < 3; r++) begin
               random_row();
               if (r == 1) while (moments_due.size() != 0) @(posedge clock);
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
